[rtl/rap_pkg.sv]
// ----------------------------------------------------------------------------
// rap_pkg
// Shared types, codes and the sine table generator for the point rotation block.
// ----------------------------------------------------------------------------
package rap_pkg;

   // Fixed widths of the configuration registers.
   localparam int AXIS_WIDTH  = 2;
   localparam int ANGLE_WIDTH = 9;

   // Quarter-wave table spans 0 to 90 degrees inclusive.
   localparam int TABLE_LAST  = 90;
   localparam int TABLE_IDX_W = 7;

   // Angle breakpoints in degrees.
   localparam int QUARTER_TURN = 90;
   localparam int HALF_TURN    = 180;
   localparam int THREE_QUARTER_TURN = 270;
   localparam int FULL_TURN    = 360;

   // Pi in Q2.30, used when the table is generated at elaboration.
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   // Configuration register indexes.
   localparam logic CSR_AXIS  = 1'b0;
   localparam logic CSR_ANGLE = 1'b1;

   // Rotation axis codes; the spare code leaves points unchanged.
   typedef enum logic [AXIS_WIDTH-1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   // Per-stage load enables of the arithmetic pipeline.
   typedef struct packed {
      logic load;
      logic mul;
      logic rnd;
      logic sum;
   } stage_ctl_type;

   // One quarter-wave sine entry, round(2^frac * sin(deg)), from a fixed-point
   // Taylor series in Q30. Only evaluated on constants during elaboration.
   function automatic longint unsigned sine_entry(input int unsigned deg,
                                                  input int unsigned frac);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned pos;
      longint unsigned neg;
      x    = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      neg  = 64'd0;
      for (int k = 1; k <= 10; k++) begin
         term = (term * x2) >> 30;
         // Series denominators (2k)(2k+1) for k from one to ten.
         unique case (k)
            1:       term = term / 64'd6;
            2:       term = term / 64'd20;
            3:       term = term / 64'd42;
            4:       term = term / 64'd72;
            5:       term = term / 64'd110;
            6:       term = term / 64'd156;
            7:       term = term / 64'd210;
            8:       term = term / 64'd272;
            9:       term = term / 64'd342;
            default: term = term / 64'd420;
         endcase
         if ((k % 2) == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      return ((pos - neg) * (64'd1 << frac) + (64'd1 << 29)) >> 30;
   endfunction

endpackage

[rtl/axis_rotation_of_points_top.sv]
// ----------------------------------------------------------------------------
// axis_rotation_of_points_top
// Rotates a stream of Q16.16 points about the x, y or z axis.
// ----------------------------------------------------------------------------
// Usage: software writes the axis (index 0) and the angle in whole degrees
// (index 1) on the csr_ port while no item is in flight; each write reloads the
// cosine and sine coefficients. Points enter on the req_ channel, tdata holding
// x, y and z from the lowest bit up, tlast marking the final point of a set.
// Each point leaves as one rotated point on the rsp_ channel in the same order,
// with the same packing and tlast copied through.
// The pipeline has four register stages: operand select, multiply, round and
// sum/saturate. rsp_tvalid rises once an accepted item reaches the last stage.
// One item is taken per cycle for as long as the receiver takes them. When
// rsp_tready is low, stages stay loaded and bubbles close up, so req_tready
// drops only once all four stages hold items.
// Reset empties the pipeline and returns to the x axis at zero degrees.
// ----------------------------------------------------------------------------
module axis_rotation_of_points_top #(
   parameter int COORD_WIDTH = 32,
   parameter int COEF_WIDTH  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration write port.
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [rap_pkg::ANGLE_WIDTH-1:0]       csr_wdata,
   // Input points.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    req_tdata,  // point_x, point_y, point_z
   input  logic                                  req_tlast,
   // Rotated points.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]    rsp_tdata,  // rotated_x, rotated_y, rotated_z
   output logic                                  rsp_tlast
);
   import rap_pkg::*;

   localparam int TDATA_W = ((3*COORD_WIDTH+7)/8)*8;
   localparam int FRAC    = COEF_WIDTH - 2;
   localparam int LANES   = 3;
   localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = {2'b01, {FRAC{1'b0}}};

   axis_type                       axis;
   logic signed [COEF_WIDTH-1:0]   cos_c, sin_c;
   logic signed [COORD_WIDTH-1:0]  pt [LANES];
   logic signed [COORD_WIDTH-1:0]  op_u [LANES];
   logic signed [COORD_WIDTH-1:0]  op_v [LANES];
   logic signed [COEF_WIDTH-1:0]   op_ku [LANES];
   logic signed [COEF_WIDTH-1:0]   op_kv [LANES];
   logic                           op_sub [LANES];
   logic signed [COORD_WIDTH-1:0]  res [LANES];
   stage_ctl_type                  ctl;

   logic adv1, adv2, adv3, adv4;
   logic s1_vld_ff, s1_vld_in, s2_vld_ff, s2_vld_in;
   logic s3_vld_ff, s3_vld_in, s4_vld_ff, s4_vld_in;
   logic last1_ff, last2_ff, last3_ff, last4_ff;

   // Configuration and coefficients.
   rap_coef #(.COEF_WIDTH(COEF_WIDTH)) u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .axis      (axis),
      .cos_coef  (cos_c),
      .sin_coef  (sin_c)
   );

   // Unpack the incoming point.
   assign pt[0] = req_tdata[COORD_WIDTH-1:0];
   assign pt[1] = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
   assign pt[2] = req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

   // Operand routing per axis; a lane on the axis multiplies by one and adds zero.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         op_u[i]   = pt[i];
         op_v[i]   = pt[i];
         op_ku[i]  = COEF_ONE;
         op_kv[i]  = '0;
         op_sub[i] = 1'b0;
      end
      unique case (axis)
         AXIS_X: begin
            op_u[1] = pt[1]; op_ku[1] = cos_c; op_v[1] = pt[2]; op_kv[1] = sin_c;
            op_sub[1] = 1'b1;
            op_u[2] = pt[1]; op_ku[2] = sin_c; op_v[2] = pt[2]; op_kv[2] = cos_c;
         end
         AXIS_Y: begin
            op_u[0] = pt[0]; op_ku[0] = cos_c; op_v[0] = pt[2]; op_kv[0] = sin_c;
            op_u[2] = pt[2]; op_ku[2] = cos_c; op_v[2] = pt[0]; op_kv[2] = sin_c;
            op_sub[2] = 1'b1;
         end
         AXIS_Z: begin
            op_u[0] = pt[0]; op_ku[0] = cos_c; op_v[0] = pt[1]; op_kv[0] = sin_c;
            op_sub[0] = 1'b1;
            op_u[1] = pt[0]; op_ku[1] = sin_c; op_v[1] = pt[1]; op_kv[1] = cos_c;
         end
         AXIS_NONE: begin
            op_sub[0] = 1'b0;
         end
         default: begin
            op_sub[0] = 1'b0;
         end
      endcase
   end

   // A stage advances when it is empty or the next one advances.
   assign adv4 = !s4_vld_ff || rsp_tready;
   assign adv3 = !s3_vld_ff || adv4;
   assign adv2 = !s2_vld_ff || adv3;
   assign adv1 = !s1_vld_ff || adv2;

   assign ctl.load = adv1;
   assign ctl.mul  = adv2;
   assign ctl.rnd  = adv3;
   assign ctl.sum  = adv4;

   assign s1_vld_in = adv1 ? req_tvalid : s1_vld_ff;
   assign s2_vld_in = adv2 ? s1_vld_ff  : s2_vld_ff;
   assign s3_vld_in = adv3 ? s2_vld_ff  : s3_vld_ff;
   assign s4_vld_in = adv4 ? s3_vld_ff  : s4_vld_ff;

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
         s4_vld_ff <= s4_vld_in;
      end
   end

   // The last flag follows the same stages.
   always_ff @(posedge clock) begin
      if (adv1) last1_ff <= req_tlast;
      if (adv2) last2_ff <= last1_ff;
      if (adv3) last3_ff <= last2_ff;
      if (adv4) last4_ff <= last3_ff;
   end

   // One arithmetic lane per output coordinate.
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      rap_lane #(
         .COORD_WIDTH (COORD_WIDTH),
         .COEF_WIDTH  (COEF_WIDTH)
      ) u_lane (
         .clock  (clock),
         .ctl    (ctl),
         .op_u   (op_u[g]),
         .op_v   (op_v[g]),
         .op_ku  (op_ku[g]),
         .op_kv  (op_kv[g]),
         .op_sub (op_sub[g]),
         .result (res[g])
      );
   end

   assign req_tready = adv1;
   assign rsp_tvalid = s4_vld_ff;
   assign rsp_tlast  = last4_ff;
   assign rsp_tdata  = TDATA_W'({res[2], res[1], res[0]});

`ifndef ASSERT_OFF
   // A full pipeline facing a stalled receiver must refuse input.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && s2_vld_ff && s3_vld_ff && s4_vld_ff && !rsp_tready |-> !req_tready)
      else $error("input accepted into a full pipeline");
   // An accepted item lands in the first stage.
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_vld_ff)
      else $error("accepted item not held in first stage");
   // An item moving out of the round stage appears at the output.
   a_sum_to_out: assert property (@(posedge clock) disable iff (reset)
      s3_vld_ff && adv4 |=> rsp_tvalid)
      else $error("item lost between round and output stages");
`endif

endmodule

[rtl/rap_coef.sv]
// ----------------------------------------------------------------------------
// rap_coef
// Configuration registers and the cosine/sine coefficient loader.
// ----------------------------------------------------------------------------
module rap_coef #(
   parameter int COEF_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [rap_pkg::ANGLE_WIDTH-1:0]      csr_wdata,
   output rap_pkg::axis_type                    axis,
   output logic signed [COEF_WIDTH-1:0]         cos_coef,
   output logic signed [COEF_WIDTH-1:0]         sin_coef
);
   import rap_pkg::*;

   localparam int FRAC    = COEF_WIDTH - 2;
   localparam int TW      = COEF_WIDTH - 1;
   localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = {2'b01, {FRAC{1'b0}}};

   axis_type                      axis_ff, axis_in;
   logic [ANGLE_WIDTH-1:0]        angle_ff, angle_in;
   logic signed [COEF_WIDTH-1:0]  cos_ff, cos_in;
   logic signed [COEF_WIDTH-1:0]  sin_ff, sin_in;

   logic [TW-1:0]                 sine_rom [0:TABLE_LAST];
   logic [ANGLE_WIDTH-1:0]        deg;
   logic [ANGLE_WIDTH-1:0]        s_off;
   logic [ANGLE_WIDTH-1:0]        c_off;
   logic                          s_neg;
   logic                          c_neg;
   logic signed [COEF_WIDTH-1:0]  s_mag;
   logic signed [COEF_WIDTH-1:0]  c_mag;

   // Constant quarter-wave table, built at elaboration for this precision.
   for (genvar g = 0; g <= TABLE_LAST; g++) begin : g_rom
      assign sine_rom[g] = TW'(sine_entry(g, FRAC));
   end

   // New register values for the write in progress.
   always_comb begin
      axis_in  = axis_ff;
      angle_in = angle_ff;
      unique case (csr_index)
         CSR_AXIS:  axis_in  = axis_type'(csr_wdata[AXIS_WIDTH-1:0]);
         CSR_ANGLE: angle_in = csr_wdata;
         default:   axis_in  = axis_ff;
      endcase
   end

   // Reduce the angle once and fold it into the first quadrant.
   always_comb begin
      if (angle_in >= ANGLE_WIDTH'(FULL_TURN)) begin
         deg = angle_in - ANGLE_WIDTH'(FULL_TURN);
      end else begin
         deg = angle_in;
      end
      priority if (deg <= ANGLE_WIDTH'(QUARTER_TURN)) begin
         s_off = deg;
         c_off = ANGLE_WIDTH'(QUARTER_TURN) - deg;
         s_neg = 1'b0;
         c_neg = 1'b0;
      end else if (deg <= ANGLE_WIDTH'(HALF_TURN)) begin
         s_off = ANGLE_WIDTH'(HALF_TURN) - deg;
         c_off = deg - ANGLE_WIDTH'(QUARTER_TURN);
         s_neg = 1'b0;
         c_neg = 1'b1;
      end else if (deg <= ANGLE_WIDTH'(THREE_QUARTER_TURN)) begin
         s_off = deg - ANGLE_WIDTH'(HALF_TURN);
         c_off = ANGLE_WIDTH'(THREE_QUARTER_TURN) - deg;
         s_neg = 1'b1;
         c_neg = 1'b1;
      end else begin
         s_off = ANGLE_WIDTH'(FULL_TURN) - deg;
         c_off = deg - ANGLE_WIDTH'(THREE_QUARTER_TURN);
         s_neg = 1'b1;
         c_neg = 1'b0;
      end
   end

   // Table lookup and sign of each coefficient.
   always_comb begin
      s_mag  = $signed({1'b0, sine_rom[s_off[TABLE_IDX_W-1:0]]});
      c_mag  = $signed({1'b0, sine_rom[c_off[TABLE_IDX_W-1:0]]});
      sin_in = s_neg ? -s_mag : s_mag;
      cos_in = c_neg ? -c_mag : c_mag;
   end

   // Registers load on every write to either index.
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff  <= AXIS_X;
         angle_ff <= '0;
         cos_ff   <= COEF_ONE;
         sin_ff   <= '0;
      end else if (csr_we) begin
         axis_ff  <= axis_in;
         angle_ff <= angle_in;
         cos_ff   <= cos_in;
         sin_ff   <= sin_in;
      end
   end

   assign axis     = axis_ff;
   assign cos_coef = cos_ff;
   assign sin_coef = sin_ff;

`ifndef ASSERT_OFF
   // Coefficients never leave the unit circle range.
   a_sin_range: assert property (@(posedge clock) disable iff (reset)
      (sin_ff <= COEF_ONE) && (sin_ff >= -COEF_ONE))
      else $error("sine coefficient out of range");
   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      (cos_ff <= COEF_ONE) && (cos_ff >= -COEF_ONE))
      else $error("cosine coefficient out of range");
   // An axis write keeps the stored angle.
   a_axis_keeps_angle: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == CSR_AXIS) |=> $stable(angle_ff))
      else $error("axis write changed the angle");
`endif

endmodule

[rtl/rap_lane.sv]
// ----------------------------------------------------------------------------
// rap_lane
// One output coordinate: two products, rounding, sum or difference, saturation.
// ----------------------------------------------------------------------------
module rap_lane #(
   parameter int COORD_WIDTH = 32,
   parameter int COEF_WIDTH  = 16
) (
   input  logic                           clock,
   input  rap_pkg::stage_ctl_type         ctl,
   input  logic signed [COORD_WIDTH-1:0]  op_u,
   input  logic signed [COORD_WIDTH-1:0]  op_v,
   input  logic signed [COEF_WIDTH-1:0]   op_ku,
   input  logic signed [COEF_WIDTH-1:0]   op_kv,
   input  logic                           op_sub,
   output logic signed [COORD_WIDTH-1:0]  result
);
   import rap_pkg::*;

   localparam int FRAC = COEF_WIDTH - 2;
   localparam int PW   = COORD_WIDTH + COEF_WIDTH;
   localparam int RW   = COORD_WIDTH + 2;
   localparam int SW   = COORD_WIDTH + 3;
   localparam logic signed [PW-1:0] HALF_ULP = {{(PW-1){1'b0}}, 1'b1} << (FRAC - 1);
   localparam logic signed [SW-1:0] SAT_MAX  = SW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam logic signed [SW-1:0] SAT_MIN  = ~SAT_MAX;

   logic signed [COORD_WIDTH-1:0] u_ff, v_ff;
   logic signed [COEF_WIDTH-1:0]  ku_ff, kv_ff;
   logic                          sub1_ff, sub2_ff, sub3_ff;
   logic signed [PW-1:0]          pu_ff, pu_in, pv_ff, pv_in;
   logic signed [PW-1:0]          pu_sh, pv_sh;
   logic signed [RW-1:0]          ru_ff, rv_ff;
   logic signed [SW-1:0]          sum;
   logic signed [COORD_WIDTH-1:0] res_ff, res_in;

   // Products in full precision.
   assign pu_in = PW'(u_ff) * PW'(ku_ff);
   assign pv_in = PW'(v_ff) * PW'(kv_ff);

   // Round each product to nearest, ties upward.
   assign pu_sh = (pu_ff + HALF_ULP) >>> FRAC;
   assign pv_sh = (pv_ff + HALF_ULP) >>> FRAC;

   // Exact sum or difference, then clamp to the coordinate range.
   always_comb begin
      if (sub3_ff) begin
         sum = SW'(ru_ff) - SW'(rv_ff);
      end else begin
         sum = SW'(ru_ff) + SW'(rv_ff);
      end
      priority if (sum > SAT_MAX) begin
         res_in = SAT_MAX[COORD_WIDTH-1:0];
      end else if (sum < SAT_MIN) begin
         res_in = SAT_MIN[COORD_WIDTH-1:0];
      end else begin
         res_in = sum[COORD_WIDTH-1:0];
      end
   end

   // Pipeline registers, each stage loads when its enable is set.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         u_ff    <= op_u;
         v_ff    <= op_v;
         ku_ff   <= op_ku;
         kv_ff   <= op_kv;
         sub1_ff <= op_sub;
      end
      if (ctl.mul) begin
         pu_ff   <= pu_in;
         pv_ff   <= pv_in;
         sub2_ff <= sub1_ff;
      end
      if (ctl.rnd) begin
         ru_ff   <= pu_sh[RW-1:0];
         rv_ff   <= pv_sh[RW-1:0];
         sub3_ff <= sub2_ff;
      end
      if (ctl.sum) begin
         res_ff  <= res_in;
      end
   end

   assign result = res_ff;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the principal-axis point rotation block. A short
// table of hand-picked points and settings runs first, then random points
// under many axis and angle settings. Every rotated point that comes back is
// compared field by field with a hand-set value or a local fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;
   import rap_pkg::*;

   localparam int COORD_W       = 32;
   localparam int COEF_FRAC     = 14;
   localparam longint ROUND_HALF = 64'sd8192;
   localparam int DATA_W        = ((3*COORD_W+7)/8)*8;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SEGMENTS      = 6;
   localparam int SEG_ITEMS     = 30;
   localparam int HOLD_CYCLES   = 64;

   localparam logic signed [31:0] COORD_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] COORD_MIN = 32'sh80000000;

   // One point, x in the lowest bits, as it travels on tdata plus tlast.
   typedef struct packed {
      logic              last;
      logic signed [31:0] z;
      logic signed [31:0] y;
      logic signed [31:0] x;
   } coord_set_type;

   typedef enum logic {ROW_CONFIG, ROW_POINT} row_kind_type;

   // One step of the directed table: a register setting or a point.
   typedef struct packed {
      row_kind_type           kind;
      logic [ANGLE_WIDTH-1:0] axis_w;
      logic [ANGLE_WIDTH-1:0] angle_w;
      coord_set_type          pt;
      logic                   typed;
      coord_set_type          want;
   } dir_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic                   csr_index  = CSR_AXIS;
   logic [ANGLE_WIDTH-1:0] csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata  = '0;  // point_x, point_y, point_z
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [DATA_W-1:0]      rsp_tdata;        // rotated_x, rotated_y, rotated_z
   logic                   rsp_tlast;

   // Predictor state: the current settings and the coefficients they load.
   axis_type               cur_axis  = AXIS_X;
   logic [ANGLE_WIDTH-1:0] cur_angle = '0;
   logic signed [15:0]     cos_q14   = 16'sd16384;
   logic signed [15:0]     sin_q14   = 16'sd0;
   logic signed [15:0]     sine_rom [0:TABLE_LAST];

   coord_set_type rotated_pending [$];
   int            mismatch_count = 0;
   int            quiet_cycles   = 0;
   int            send_idle_pct  = 0;
   int            rcv_stall_pct  = 0;
   int            hold_left      = 0;

   axis_rotation_of_points_top #(
      .COORD_WIDTH(COORD_W),
      .COEF_WIDTH (16)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Sine of a whole degree in Q14, from an eleven-term series evaluated in Q30.
   function automatic longint unsigned quarter_wave(int unsigned deg);
      longint unsigned rad, rad_sq, term, plus_sum, minus_sum, denom;
      rad       = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
      rad_sq    = (rad * rad) >> 30;
      term      = rad;
      plus_sum  = rad;
      minus_sum = 64'd0;
      for (int k = 1; k <= 10; k++) begin
         denom = 64'(2 * k) * 64'(2 * k + 1);
         term  = ((term * rad_sq) >> 30) / denom;
         if ((k % 2) == 1) begin
            minus_sum += term;
         end else begin
            plus_sum += term;
         end
      end
      return (((plus_sum - minus_sum) << COEF_FRAC) + (64'd1 << 29)) >> 30;
   endfunction

   // Cosine and sine for the current angle, folded onto the quarter wave.
   function automatic void reload_coefs();
      int d;
      d = int'(cur_angle);
      if (d >= FULL_TURN) d -= FULL_TURN;
      if (d <= QUARTER_TURN) begin
         sin_q14 = sine_rom[d];
         cos_q14 = sine_rom[QUARTER_TURN - d];
      end else if (d <= HALF_TURN) begin
         sin_q14 = sine_rom[HALF_TURN - d];
         cos_q14 = -sine_rom[d - QUARTER_TURN];
      end else if (d <= THREE_QUARTER_TURN) begin
         sin_q14 = -sine_rom[d - HALF_TURN];
         cos_q14 = -sine_rom[THREE_QUARTER_TURN - d];
      end else begin
         sin_q14 = -sine_rom[FULL_TURN - d];
         cos_q14 = sine_rom[d - THREE_QUARTER_TURN];
      end
   endfunction

   // Product of a coordinate and a coefficient, rounded half up to Q16.16.
   function automatic longint round_prod(logic signed [31:0] coord,
                                         logic signed [15:0] coef);
      return (longint'(coord) * longint'(coef) + ROUND_HALF) >>> COEF_FRAC;
   endfunction

   function automatic logic signed [31:0] clamp_coord(longint v);
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      if (v < longint'(COORD_MIN)) return COORD_MIN;
      return v[31:0];
   endfunction

   // Expected rotated point under the current settings.
   function automatic coord_set_type rotate_point(coord_set_type p);
      coord_set_type r;
      r = p;
      case (cur_axis)
         AXIS_X: begin
            r.y = clamp_coord(round_prod(p.y, cos_q14) - round_prod(p.z, sin_q14));
            r.z = clamp_coord(round_prod(p.y, sin_q14) + round_prod(p.z, cos_q14));
         end
         AXIS_Y: begin
            r.x = clamp_coord(round_prod(p.x, cos_q14) + round_prod(p.z, sin_q14));
            r.z = clamp_coord(round_prod(p.z, cos_q14) - round_prod(p.x, sin_q14));
         end
         AXIS_Z: begin
            r.x = clamp_coord(round_prod(p.x, cos_q14) - round_prod(p.y, sin_q14));
            r.y = clamp_coord(round_prod(p.x, sin_q14) + round_prod(p.y, cos_q14));
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic coord_set_type coords(logic signed [31:0] x, logic signed [31:0] y,
                                            logic signed [31:0] z, logic last);
      coord_set_type p;
      p.x    = x;
      p.y    = y;
      p.z    = z;
      p.last = last;
      return p;
   endfunction

   function automatic dir_row_type config_row(logic [ANGLE_WIDTH-1:0] axis_w,
                                              logic [ANGLE_WIDTH-1:0] angle_w);
      dir_row_type r;
      r         = '0;
      r.kind    = ROW_CONFIG;
      r.axis_w  = axis_w;
      r.angle_w = angle_w;
      return r;
   endfunction

   function automatic dir_row_type point_row(coord_set_type p);
      dir_row_type r;
      r      = '0;
      r.kind = ROW_POINT;
      r.pt   = p;
      return r;
   endfunction

   function automatic dir_row_type known_row(coord_set_type p, coord_set_type w);
      dir_row_type r;
      r       = point_row(p);
      r.typed = 1'b1;
      r.want  = w;
      return r;
   endfunction

   // Full-range and small Q16.16 values in equal share, and sometimes the extremes.
   function automatic logic signed [31:0] random_coord();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 4) return $urandom;
      if (pick < 8) return int'($urandom_range(2097151)) - 1048576;
      case ($urandom_range(4))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return 32'sd0;
         3:       return -32'sd1;
         default: return 32'sd1;
      endcase
   endfunction

   // Both registers are written back to back; each write reloads the coefficients.
   task automatic write_config(logic [ANGLE_WIDTH-1:0] axis_w,
                               logic [ANGLE_WIDTH-1:0] angle_w);
      csr_we    <= 1'b1;
      csr_index <= CSR_AXIS;
      csr_wdata <= axis_w;
      @(posedge clock);
      csr_index <= CSR_ANGLE;
      csr_wdata <= angle_w;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_axis  = axis_type'(axis_w[AXIS_WIDTH-1:0]);
      cur_angle = angle_w;
      reload_coefs();
   endtask

   // Offers one item, with an optional idle gap first, and records its result.
   task automatic send_point(coord_set_type p, coord_set_type want);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {p.z, p.y, p.x};
      req_tlast  <= p.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      rotated_pending.push_back(want);
   endtask

   // Stops offering items and waits for the pipeline to empty.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (rotated_pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic report_mismatch(string field, logic [31:0] want_v, logic [31:0] got_v);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rcv_stall_pct);
         end
      end
   end

   // Each accepted result is compared with the oldest expected point.
   always @(posedge clock) begin
      coord_set_type exp_pt;
      coord_set_type got_pt;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_pt = coords(rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tlast);
         if (rotated_pending.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected item, expected none, got %h", $time, got_pt);
         end else begin
            exp_pt = rotated_pending.pop_front();
            if (got_pt.x !== exp_pt.x) report_mismatch("rotated_x", exp_pt.x, got_pt.x);
            if (got_pt.y !== exp_pt.y) report_mismatch("rotated_y", exp_pt.y, got_pt.y);
            if (got_pt.z !== exp_pt.z) report_mismatch("rotated_z", exp_pt.z, got_pt.z);
            if (got_pt.last !== exp_pt.last) begin
               report_mismatch("last_out", 32'(exp_pt.last), 32'(got_pt.last));
            end
         end
      end
   end

   // Watchdog: too long without any item moving on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Main sequence: directed table, then three phases of random points with different idle and stall rates.
   initial begin
      dir_row_type            steps [$];
      int                     extreme_angles [7];
      coord_set_type          p;
      logic [ANGLE_WIDTH-1:0] seg_angle;
      logic [1:0]             seg_axis;

      for (int d = 0; d <= TABLE_LAST; d++) begin
         sine_rom[d] = 16'(quarter_wave(d));
      end
      extreme_angles = '{0, 359, 360, 511, 90, 180, 270};

      steps = '{
         // Reset settings leave every point unchanged.
         known_row(coords(0, 0, 0, 0), coords(0, 0, 0, 0)),
         known_row(coords(COORD_MAX, COORD_MIN, COORD_MAX, 1),
                   coords(COORD_MAX, COORD_MIN, COORD_MAX, 1)),
         known_row(coords(COORD_MIN, -1, 1, 0), coords(COORD_MIN, -1, 1, 0)),
         // The spare axis code passes points through at any angle.
         config_row({7'h55, AXIS_NONE}, 9'd123),
         known_row(coords(32'sh12345678, -32'sh0ABCDEF0, COORD_MIN, 1),
                   coords(32'sh12345678, -32'sh0ABCDEF0, COORD_MIN, 1)),
         known_row(coords(COORD_MAX, COORD_MAX, COORD_MAX, 0),
                   coords(COORD_MAX, COORD_MAX, COORD_MAX, 0)),
         // Half turn about x negates y and z; the most negative value saturates.
         config_row({7'd0, AXIS_X}, 9'd180),
         known_row(coords(5, COORD_MIN, COORD_MAX, 0),
                   coords(5, COORD_MAX, 32'sh80000001, 0)),
         known_row(coords(-7, 32'sh00010000, -32'sh00020000, 1),
                   coords(-7, -32'sh00010000, 32'sh00020000, 1)),
         // At 45 degrees equal y and z cancel in y and overflow in z.
         config_row({7'd0, AXIS_X}, 9'd45),
         known_row(coords(COORD_MIN, COORD_MAX, COORD_MAX, 1),
                   coords(COORD_MIN, 0, COORD_MAX, 1)),
         point_row(coords(0, COORD_MIN, COORD_MAX, 0)),
         config_row({7'd0, AXIS_Y}, 9'd90),
         point_row(coords(COORD_MAX, 3, COORD_MIN, 0)),
         point_row(coords(-32'sh00018000, 0, 32'sh00030000, 1)),
         config_row({7'd0, AXIS_Z}, 9'd270),
         point_row(coords(32'sh00010000, -32'sh00010000, 9, 0)),
         point_row(coords(COORD_MIN, COORD_MIN, COORD_MIN, 1)),
         // A cosine of one half puts odd coordinates on rounding ties.
         config_row({7'd0, AXIS_Z}, 9'd60),
         point_row(coords(1, 0, 0, 0)),
         point_row(coords(-1, 0, 0, 0)),
         point_row(coords(32'sh00002001, -3, 0, 1)),
         config_row({7'd0, AXIS_Z}, 9'd359),
         point_row(coords(COORD_MAX, COORD_MIN, 4, 0)),
         // Angles past 359 wrap once.
         config_row({7'd0, AXIS_Y}, 9'd511),
         point_row(coords(32'sh7FFF0000, 32'sh00001000, -32'sh7FFF0000, 1)),
         config_row({7'd0, AXIS_Y}, 9'd360),
         known_row(coords(123456, COORD_MIN, -123456, 0),
                   coords(123456, COORD_MIN, -123456, 0))
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 33;
      rcv_stall_pct = 54;
      foreach (steps[i]) begin
         if (steps[i].kind == ROW_CONFIG) begin
            drain();
            write_config(steps[i].axis_w, steps[i].angle_w);
         end else begin
            send_point(steps[i].pt,
                       steps[i].typed ? steps[i].want : rotate_point(steps[i].pt));
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 54 : 0;
         rcv_stall_pct = (phase == 0) ? 54 : (phase == 1) ? 33 : 0;
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            // Early segments sweep the axis codes and the extreme angles.
            if (seg < 4) begin
               seg_axis  = 2'((seg + phase) % 4);
               seg_angle = ANGLE_WIDTH'(extreme_angles[(phase * 4 + seg) % 7]);
            end else begin
               seg_axis  = 2'($urandom_range(2));
               seg_angle = ($urandom_range(3) == 0) ? ANGLE_WIDTH'($urandom_range(360, 511))
                                                    : ANGLE_WIDTH'($urandom_range(359));
            end
            drain();
            write_config({7'($urandom_range(127)), seg_axis}, seg_angle);
            // Hold the receiver off so the pipeline fills and stalls the input.
            if (phase == 2 && seg == 0) hold_left = HOLD_CYCLES;
            for (int i = 0; i < SEG_ITEMS; i++) begin
               p = coords(random_coord(), random_coord(), random_coord(),
                          ($urandom_range(7) == 0));
               send_point(p, rotate_point(p));
            end
         end
      end

      drain();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/rap_pkg.sv
rtl/rap_coef.sv
rtl/rap_lane.sv
rtl/axis_rotation_of_points_top.sv
bench/tb.sv
